>>> hw/rtl/empirical_cdf_inverse_sampler_assert.svh
// assertion macros for the empirical cdf inverse sampler
// no dependencies; included by ecdf_ctrl, which carries the assertions
`ifndef EMPIRICAL_CDF_INVERSE_SAMPLER_ASSERT_SVH
`define EMPIRICAL_CDF_INVERSE_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ECDF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ECDF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ECDF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define ECDF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/ecdf_pkg.sv
// shared types and constants for the empirical cdf inverse sampler
// no dependencies
`default_nettype none
package ecdf_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam int OP_W    = 2;
   localparam int VALUE_W = 32;
   localparam int PROB_W  = 17;
   localparam int DV_W    = VALUE_W + 1;   // signed value difference
   localparam int DP_W    = PROB_W + 1;    // signed probability difference
   localparam int PROD_W  = DV_W + DP_W;   // signed product
   localparam int MAG_W   = PROD_W - 1;    // product magnitude
   localparam int QS_W    = MAG_W + 1;     // signed quotient
   localparam int SUM_W   = QS_W + 2;      // value plus quotient
   localparam int DIV_CNT_W = $clog2(MAG_W);

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [VALUE_W-1:0] ONE_VALUE = 32'd65536;
   localparam logic [PROB_W-1:0]  ONE_PROB  = 17'd65536;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRIME,
      ST_LOAD,
      ST_SCAN,
      ST_DIFF,
      ST_MUL,
      ST_MAG,
      ST_DIV,
      ST_SIGN,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic append;
      logic clear;
      logic smp_start;
      logic rd_adv;
      logic lo_load;
      logic seg_latch;
      logic diff;
      logic mul;
      logic mag;
      logic div_step;
      logic sign;
      logic fin;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic multi;
      logic hit;
      logic last;
      logic dp_zero;
   } dp_stat_type;

endpackage
`default_nettype wire

>>> hw/rtl/ecdf_datapath.sv
// table memory, segment scan, multiply, divide and saturation datapath
// depends on ecdf_pkg
`default_nettype none
module ecdf_datapath import ecdf_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_cmd_type        cmd,
   output dp_stat_type             stat,
   input  wire logic [VALUE_W-1:0] req_point_value,
   input  wire logic [PROB_W-1:0]  req_point_prob,
   input  wire logic [PROB_W-1:0]  req_uniform_prob,
   output logic      [VALUE_W-1:0] rsp_sample_value,
   output logic                    rsp_out_of_range
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   logic [VALUE_W-1:0] mem_value [TABLE_DEPTH];
   logic [PROB_W-1:0]  mem_prob  [TABLE_DEPTH];

   logic [CNT_W-1:0]   point_count_ff;
   logic [CNT_W-1:0]   rd_addr_ff;
   logic [VALUE_W-1:0] rd_value_ff;
   logic [PROB_W-1:0]  rd_prob_ff;
   logic [PROB_W-1:0]  u_ff;
   logic [VALUE_W-1:0] lo_value_ff;
   logic [PROB_W-1:0]  lo_prob_ff;
   logic [VALUE_W-1:0] v1_ff;
   logic [PROB_W-1:0]  p1_ff;
   logic [VALUE_W-1:0] v2_ff;
   logic [PROB_W-1:0]  p2_ff;
   logic               hit_ff;
   logic [DV_W-1:0]    dv_ff;
   logic [DP_W-1:0]    du_ff;
   logic [DP_W-1:0]    dp_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [MAG_W-1:0]   quo_ff;
   logic [DP_W-1:0]    rem_ff;
   logic [PROB_W-1:0]  dvsr_ff;
   logic               neg_ff;
   logic [QS_W-1:0]    qs_ff;
   logic [VALUE_W-1:0] sample_ff;
   logic               oor_ff;

   logic               hit_now;
   logic [PROD_W-1:0]  prod_abs;
   logic [DP_W-1:0]    dp_abs;
   logic [DP_W-1:0]    rem_shift;
   logic               rem_ge;
   logic [DP_W-1:0]    rem_in;
   logic [MAG_W-1:0]   quo_in;
   logic [QS_W-1:0]    qs_in;
   logic [SUM_W-1:0]   sum;

   assign hit_now = (u_ff >= lo_prob_ff) && (u_ff <= rd_prob_ff);

   assign stat.full    = (point_count_ff == DEPTH_CNT);
   assign stat.multi   = (point_count_ff >= CNT_W'(2));
   assign stat.hit     = hit_now;
   assign stat.last    = (rd_addr_ff == point_count_ff);
   assign stat.dp_zero = (dp_ff == '0);

   // table storage, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem_value[point_count_ff[ADDR_W-1:0]] <= req_point_value;
         mem_prob[point_count_ff[ADDR_W-1:0]]  <= req_point_prob;
      end
      rd_value_ff <= mem_value[rd_addr_ff[ADDR_W-1:0]];
      rd_prob_ff  <= mem_prob[rd_addr_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         rd_addr_ff     <= '0;
      end else begin
         if (cmd.clear) begin
            point_count_ff <= '0;
         end else if (cmd.append) begin
            point_count_ff <= point_count_ff + CNT_W'(1);
         end
         if (cmd.smp_start) begin
            rd_addr_ff <= '0;
         end else if (cmd.rd_adv) begin
            rd_addr_ff <= rd_addr_ff + CNT_W'(1);
         end
      end
   end

   // magnitudes for the unsigned divider
   assign prod_abs = prod_ff[PROD_W-1] ? (~prod_ff + PROD_W'(1)) : prod_ff;
   assign dp_abs   = dp_ff[DP_W-1] ? (~dp_ff + DP_W'(1)) : dp_ff;

   // restoring divide, one quotient bit per step
   assign rem_shift = {rem_ff[PROB_W-1:0], quo_ff[MAG_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, dvsr_ff});
   assign rem_in    = rem_ge ? (rem_shift - {1'b0, dvsr_ff}) : rem_shift;
   assign quo_in    = {quo_ff[MAG_W-2:0], rem_ge};

   always_comb begin
      if (stat.dp_zero) begin
         qs_in = '0;
      end else if (neg_ff) begin
         qs_in = ~{1'b0, quo_ff} + QS_W'(1);
      end else begin
         qs_in = {1'b0, quo_ff};
      end
   end

   assign sum = {{(SUM_W - VALUE_W){1'b0}}, v1_ff} + {{(SUM_W - QS_W){qs_ff[QS_W-1]}}, qs_ff};

   always_ff @(posedge clock) begin
      if (cmd.smp_start) begin
         u_ff   <= req_uniform_prob;
         v1_ff  <= '0;
         p1_ff  <= '0;
         v2_ff  <= ONE_VALUE;
         p2_ff  <= ONE_PROB;
         hit_ff <= (req_uniform_prob <= ONE_PROB);
      end else if (cmd.seg_latch) begin
         v1_ff  <= lo_value_ff;
         p1_ff  <= lo_prob_ff;
         v2_ff  <= rd_value_ff;
         p2_ff  <= rd_prob_ff;
         hit_ff <= hit_now;
      end
      if (cmd.lo_load) begin
         lo_value_ff <= rd_value_ff;
         lo_prob_ff  <= rd_prob_ff;
      end
      if (cmd.diff) begin
         dv_ff <= {1'b0, v2_ff} - {1'b0, v1_ff};
         du_ff <= {1'b0, u_ff} - {1'b0, p1_ff};
         dp_ff <= {1'b0, p2_ff} - {1'b0, p1_ff};
      end
      if (cmd.mul) begin
         prod_ff <= $signed(dv_ff) * $signed(du_ff);
      end
      if (cmd.mag) begin
         quo_ff  <= prod_abs[MAG_W-1:0];
         dvsr_ff <= dp_abs[PROB_W-1:0];
         rem_ff  <= '0;
         neg_ff  <= prod_ff[PROD_W-1] ^ dp_ff[DP_W-1];
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.sign) begin
         qs_ff <= qs_in;
      end
      if (cmd.fin) begin
         oor_ff <= !hit_ff;
         if (sum[SUM_W-1]) begin
            sample_ff <= '0;
         end else if (|sum[SUM_W-2:VALUE_W]) begin
            sample_ff <= '1;
         end else begin
            sample_ff <= sum[VALUE_W-1:0];
         end
      end
   end

   assign rsp_sample_value = sample_ff;
   assign rsp_out_of_range = oor_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ecdf_ctrl.sv
// controller state machine: decodes items and sequences scan, multiply and divide
// depends on ecdf_pkg and the assertion macro header
`default_nettype none
`include "empirical_cdf_inverse_sampler_assert.svh"
module ecdf_ctrl import ecdf_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [OP_W-1:0] req_op,
   input  wire dp_stat_type     stat,
   output ctl_cmd_type          cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

   state_type state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (req_op)
                  OP_APPEND: cmd.append = !stat.full;
                  OP_CLEAR:  cmd.clear  = 1'b1;
                  OP_SAMPLE: begin
                     cmd.smp_start = 1'b1;
                     state_in      = stat.multi ? ST_PRIME : ST_DIFF;
                  end
                  default: ;
               endcase
            end
         end
         ST_PRIME: begin
            cmd.rd_adv = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.rd_adv  = 1'b1;
            cmd.lo_load = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.hit || stat.last) begin
               cmd.seg_latch = 1'b1;
               state_in      = ST_DIFF;
            end else begin
               cmd.rd_adv  = 1'b1;
               cmd.lo_load = 1'b1;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag    = 1'b1;
            div_cnt_in = '0;
            state_in   = stat.dp_zero ? ST_SIGN : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            cmd.sign = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ECDF_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_strobe, busy, "result strobe while idle")
   `ECDF_ASSERT_NEXT(a_strobe_done, clock, reset, rsp_strobe, !busy && !rsp_strobe, "no return to idle after result")
   `ECDF_ASSERT_NEXT(a_sample_busy, clock, reset, start && !busy && req_op == OP_SAMPLE, busy, "sample transfer did not start work")
   `ECDF_ASSERT_NEXT(a_table_idle, clock, reset, start && !busy && req_op != OP_SAMPLE, !busy && !rsp_strobe, "table item left idle")
   `ECDF_ASSERT_NOW(a_div_range, clock, reset, state_ff == ST_DIV, div_cnt_ff <= DIV_LAST, "divide step count overrun")

endmodule
`default_nettype wire

>>> hw/rtl/empirical_cdf_inverse_sampler.sv
// top level of the empirical cdf inverse sampler: controller plus datapath
// depends on ecdf_pkg, ecdf_ctrl and ecdf_datapath
// append and clear complete at the transfer edge; busy stays low, no result
// sample with n >= 2 points: prime and load, scan the segments, then diff, mul, mag, divide, sign, fin, out
// sample with fewer than 2 points goes straight to diff; a flat segment skips the 50-step divide
// the scan walks one entry per cycle; busy stays high until the result, so no item is taken mid-sample
// synchronous active-high reset empties the table and returns to idle; results cannot stall
`default_nettype none
module empirical_cdf_inverse_sampler import ecdf_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [OP_W-1:0]    req_op,
   input  wire logic [VALUE_W-1:0] req_point_value,
   input  wire logic [PROB_W-1:0]  req_point_prob,
   input  wire logic [PROB_W-1:0]  req_uniform_prob,
   output logic                    rsp_strobe,
   output logic      [VALUE_W-1:0] rsp_sample_value,
   output logic                    rsp_out_of_range
);

   // command and status bundles between the two halves
   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequencer: op decode, scan walk, divide step count
   ecdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_op),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // point table memory, interpolation arithmetic and saturation
   ecdf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_point_value  (req_point_value),
      .req_point_prob   (req_point_prob),
      .req_uniform_prob (req_uniform_prob),
      .rsp_sample_value (rsp_sample_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for empirical_cdf_inverse_sampler: point loads, clears and draws
// depends on ecdf_pkg and the sampler rtl; a scripted opening, then random table sets
// every draw is checked against scripted values or an in-bench inverse-cdf predictor
`default_nettype none
module tb_top;
   import ecdf_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
   localparam int ITEM_TARGET    = 1350;
   // settle well past a full-table draw at the end
   localparam int SETTLE_CYCLES  = 200;
   // ~1350 full-table draws with the longest sender gaps, several times over
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int REPORT_LIMIT   = 10;
   localparam int SCRIPT_LEN     = 25;
   localparam logic [OP_W-1:0]    OP_UNUSED       = 2'd3;
   localparam logic [VALUE_W-1:0] FILL_VALUE_STEP = 32'h0000_1000;
   localparam logic [PROB_W-1:0]  FILL_PROB_STEP  = 17'd1000;
   localparam logic [PROB_W-1:0]  PROB_ALL_ONES   = 17'h1FFFF;
   localparam longint             VALUE_MAX       = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               oor;
   } draw_result_type;

   // one scripted row; reps > 1 repeats an append with stepped value and prob
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      logic [PROB_W-1:0]  prob;
      logic [PROB_W-1:0]  u;
      logic [6:0]         reps;
      logic               typed;
      logic [VALUE_W-1:0] exp_value;
      logic               exp_oor;
   } script_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_op = OP_APPEND;
   logic [VALUE_W-1:0] req_point_value = '0;
   logic [PROB_W-1:0]  req_point_prob = '0;
   logic [PROB_W-1:0]  req_uniform_prob = '0;
   logic               rsp_strobe;
   logic [VALUE_W-1:0] rsp_sample_value;
   logic               rsp_out_of_range;

   // predictor copy of the point table
   logic [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
   logic [PROB_W-1:0]  tbl_prob  [TABLE_DEPTH];
   int                 tbl_count = 0;

   draw_result_type pending_draws [$];

   int mismatches = 0;
   int draws = 0;
   int extrapolated = 0;
   int loads = 0;
   int dropped_loads = 0;
   int clears = 0;
   int unused_ops = 0;
   int burst_left = 0;
   int cycle_count = 0;

   // opening script: empty table, extremes, flat, unsorted, saturation, full table
   script_row_type script [SCRIPT_LEN] = '{
      // empty table uses the unit segment
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd0,       7'd1, 1'b1, 32'd0,          1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd65536,   7'd1, 1'b1, 32'd65536,      1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd32768,   7'd1, 1'b1, 32'd32768,      1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'h1FFFF,   7'd1, 1'b1, 32'd131071,     1'b1},
      // unused op with every bit set, must leave the table alone
      '{OP_UNUSED, 32'hFFFF_FFFF,  17'h1FFFF,  17'h1FFFF,   7'd1, 1'b0, 32'd0,          1'b0},
      // a single point still means the unit segment
      '{OP_APPEND, 32'hFFFF_FFFF,  17'd0,      17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd16384,   7'd1, 1'b1, 32'd16384,      1'b0},
      // falling segment across the full value range, low-side saturation
      '{OP_APPEND, 32'd0,          17'd65536,  17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd0,       7'd1, 1'b1, 32'hFFFF_FFFF,  1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd65536,   7'd1, 1'b1, 32'd0,          1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'h1FFFF,   7'd1, 1'b1, 32'd0,          1'b1},
      // flat segment, hit and extrapolated
      '{OP_CLEAR,  32'd0,          17'd0,      17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_APPEND, 32'h0001_0000,  17'd100,    17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_APPEND, 32'h0002_0000,  17'd100,    17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd100,     7'd1, 1'b1, 32'h0001_0000,  1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd50,      7'd1, 1'b1, 32'h0001_0000,  1'b1},
      // unsorted point, scanned as stored
      '{OP_APPEND, 32'h0003_0000,  17'd50,     17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd75,      7'd1, 1'b0, 32'd0,          1'b0},
      // steep segment, high-side saturation
      '{OP_CLEAR,  32'd0,          17'd0,      17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_APPEND, 32'hFFFF_0000,  17'd0,      17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_APPEND, 32'hFFFF_FFFF,  17'd1,      17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd65536,   7'd1, 1'b1, 32'hFFFF_FFFF,  1'b1},
      // fill past the depth; the extra point would bracket u if it were kept
      '{OP_CLEAR,  32'd0,          17'd0,      17'd0,       7'd1, 1'b0, 32'd0,          1'b0},
      '{OP_APPEND, 32'd0,          17'd0,      17'd0,       7'd65, 1'b0, 32'd0,         1'b0},
      '{OP_SAMPLE, 32'd0,          17'd0,      17'd63500,   7'd1, 1'b0, 32'd0,          1'b0}
   };

   empirical_cdf_inverse_sampler #(
      .TABLE_DEPTH      (TABLE_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_point_value  (req_point_value),
      .req_point_prob   (req_point_prob),
      .req_uniform_prob (req_uniform_prob),
      .rsp_strobe       (rsp_strobe),
      .rsp_sample_value (rsp_sample_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // inverse cdf of the current table at probability u
   function automatic draw_result_type draw_from_table(input logic [PROB_W-1:0] u);
      longint          v_lo, p_lo, v_hi, p_hi, uu, x;
      bit              hit;
      draw_result_type d;
      // fewer than two points: unit segment
      v_lo = 0;
      p_lo = 0;
      v_hi = longint'(ONE_VALUE);
      p_hi = longint'(ONE_PROB);
      uu   = longint'(u);
      hit  = 1'b0;
      if (tbl_count >= 2) begin
         // first bracketing segment wins; otherwise the last one is kept
         for (int i = 0; i + 1 < tbl_count; i++) begin
            v_lo = longint'(tbl_value[i]);
            p_lo = longint'(tbl_prob[i]);
            v_hi = longint'(tbl_value[i+1]);
            p_hi = longint'(tbl_prob[i+1]);
            if (uu >= p_lo && uu <= p_hi) begin
               hit = 1'b1;
               break;
            end
         end
      end else begin
         hit = (uu >= p_lo && uu <= p_hi);
      end
      // flat segment returns its first value, no divide
      x = v_lo;
      if (p_hi != p_lo) begin
         x = v_lo + ((v_hi - v_lo) * (uu - p_lo)) / (p_hi - p_lo);
      end
      if (x < 0) begin
         d.value = '0;
      end else if (x > VALUE_MAX) begin
         d.value = '1;
      end else begin
         d.value = x[VALUE_W-1:0];
      end
      d.oor = ~hit;
      return d;
   endfunction

   // one transfer: bursts with random gaps, drive at the falling edge, wait for !busy
   task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input logic [PROB_W-1:0] prob, input logic [PROB_W-1:0] u,
                            input logic typed, input draw_result_type typed_draw);
      draw_result_type want;
      int              gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         // now and then a long stretch with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      @(negedge clock);
      start            <= 1'b1;
      req_op           <= op;
      req_point_value  <= value;
      req_point_prob   <= prob;
      req_uniform_prob <= u;
      do @(posedge clock); while (busy);
      // transfer taken at this edge: update the predictor in order
      case (op)
         OP_APPEND: begin
            if (tbl_count < TABLE_DEPTH) begin
               tbl_value[tbl_count] = value;
               tbl_prob[tbl_count]  = prob;
               tbl_count++;
               loads++;
            end else begin
               dropped_loads++;
            end
         end
         OP_SAMPLE: begin
            want = typed ? typed_draw : draw_from_table(u);
            pending_draws.insert(pending_draws.size(), want);
            draws++;
            if (want.oor) extrapolated++;
         end
         OP_CLEAR: begin
            tbl_count = 0;
            clears++;
         end
         default: begin
            unused_ops++;
         end
      endcase
   endtask

   // hold off the sender until every draw has come back
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
   endtask

   // result checker; strobes cannot be stalled, so every one is taken
   always @(posedge clock) begin : check_draws
      draw_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_draws.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected draw result: value %h oor %0b",
                        rsp_sample_value, rsp_out_of_range);
            end
         end else begin
            want = pending_draws.pop_front();
            if (rsp_sample_value !== want.value || rsp_out_of_range !== want.oor) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("draw mismatch: expected value %h oor %0b, got value %h oor %0b",
                           want.value, want.oor, rsp_sample_value, rsp_out_of_range);
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d draws outstanding",
                  cycle_count, pending_draws.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      int                 n_points, n_draws, pick, value_mode, stride;
      longint             p, v;
      logic [PROB_W-1:0]  u;
      logic [VALUE_W-1:0] rand_value;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // scripted opening
      for (int r = 0; r < SCRIPT_LEN; r++) begin
         for (int k = 0; k < script[r].reps; k++) begin
            send_item(script[r].op,
                      script[r].value + VALUE_W'(k) * FILL_VALUE_STEP,
                      script[r].prob + PROB_W'(k) * FILL_PROB_STEP,
                      script[r].u, script[r].typed,
                      '{script[r].exp_value, script[r].exp_oor});
         end
      end
      wait_for_drain();

      // random part: mostly clean table sets with draws, some raw noise
      while (loads + draws + clears < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 8) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       n_points = $urandom_range(0, 1);
            else if (pick < 90) n_points = $urandom_range(2, 8);
            else if (pick < 97) n_points = $urandom_range(9, 30);
            else                n_points = $urandom_range(60, 70);
            send_item(OP_CLEAR, $urandom, PROB_W'($urandom_range(0, PROB_ALL_ONES)),
                      PROB_W'($urandom_range(0, PROB_ALL_ONES)), 1'b0, '0);
            // rising probabilities, some flat steps; values rising, random or falling
            stride     = 131072 / (n_points + 1);
            value_mode = $urandom_range(0, 2);
            p = longint'($urandom_range(0, 4000));
            v = (value_mode == 2) ? longint'($urandom) : longint'($urandom_range(0, 65536));
            for (int k = 0; k < n_points; k++) begin
               if (k > 0) begin
                  if ($urandom_range(0, 5) != 0) p += longint'($urandom_range(1, stride + 1));
                  case (value_mode)
                     0:       v += longint'($urandom_range(0, 32'h0004_0000));
                     1:       v = longint'($urandom);
                     default: v -= longint'($urandom_range(0, 32'h0100_0000));
                  endcase
               end
               if (p > PROB_ALL_ONES) p = PROB_ALL_ONES;
               if (v < 0) v = 0;
               if (v > VALUE_MAX) v = VALUE_MAX;
               send_item(OP_APPEND, v[VALUE_W-1:0], p[PROB_W-1:0],
                         PROB_W'($urandom_range(0, PROB_ALL_ONES)), 1'b0, '0);
            end
            n_draws = $urandom_range(1, 8);
            for (int k = 0; k < n_draws; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 50) begin
                  u = PROB_W'($urandom_range(0, ONE_PROB));
               end else if (pick < 70 && tbl_count > 0) begin
                  // land exactly on a stored point
                  u = tbl_prob[$urandom_range(0, tbl_count - 1)];
               end else if (pick < 85) begin
                  u = PROB_W'($urandom_range(0, PROB_ALL_ONES));
               end else begin
                  case ($urandom_range(0, 2))
                     0:       u = '0;
                     1:       u = ONE_PROB;
                     default: u = PROB_ALL_ONES;
                  endcase
               end
               rand_value = $urandom;
               send_item(OP_SAMPLE, rand_value, PROB_W'($urandom_range(0, PROB_ALL_ONES)), u,
                         1'b0, '0);
            end
         end else begin
            // noise: any op, any field value, including the unused op
            n_draws = $urandom_range(1, 6);
            for (int k = 0; k < n_draws; k++) begin
               rand_value = $urandom;
               send_item(OP_W'($urandom_range(0, 3)), rand_value,
                         PROB_W'($urandom_range(0, PROB_ALL_ONES)),
                         PROB_W'($urandom_range(0, PROB_ALL_ONES)), 1'b0, '0);
            end
         end
         if ($urandom_range(0, 9) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatches += pending_draws.size();

      $display("covered %0d draws (%0d extrapolated), %0d point loads, %0d dropped when full",
               draws, extrapolated, loads, dropped_loads);
      $display("%0d table clears, %0d unused-op transfers, %0d mismatches in %0d cycles",
               clears, unused_ops, mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
